>>> rtl/wutm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed utilization monitor package
// Shared widths, register indexes, payload structs and the controller states.
// ----------------------------------------------------------------------------
package wutm_pkg;

    localparam int MAX_WINDOW_DEFAULT      = 128;
    localparam int THRESHOLD_COUNT_DEFAULT = 2;

    localparam int TICK_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PCT_W     = 15;
    localparam int WLEN_W    = 8;
    localparam int ACTION_W  = 6;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEVEL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HYSTERESIS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HYSTERESIS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTION_BITS       = 3'd5;

    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 8'd120;
    localparam logic [PCT_W-1:0]  LEVEL_RESET         = 15'd23040;
    localparam logic [PCT_W-1:0]  LEVEL_MIN           = 15'd15360;
    localparam logic [PCT_W-1:0]  LEVEL_MAX           = 15'd23040;
    localparam logic [FRAC_W-1:0] FRAC_FULL           = 16'hFFFF;

    // Action bit offsets within one threshold's three-bit group.
    localparam int ACT_LOG    = 0;
    localparam int ACT_REBOOT = 1;
    localparam int ACT_ERROR  = 2;

    typedef struct packed {
        logic [TICK_W-1:0] total_ticks;
        logic [TICK_W-1:0] idle_ticks;
    } in_item_t;

    typedef struct packed {
        logic [PCT_W-1:0] average_percent;
        logic             average_valid;
        logic [1:0]       asserted_mask;
        logic [1:0]       assert_events;
        logic [1:0]       deassert_events;
        logic [1:0]       log_events;
        logic             reboot_request;
        logic             health_error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAC_SETUP,
        ST_FRAC_DIV,
        ST_UPDATE,
        ST_AVG_SETUP,
        ST_AVG_DIV,
        ST_FINISH
    } state_t;

    function automatic logic [PCT_W-1:0] clamp_level(input logic [PCT_W-1:0] v);
        logic [PCT_W-1:0] r;
        r = v;
        if (v < LEVEL_MIN) r = LEVEL_MIN;
        if (v > LEVEL_MAX) r = LEVEL_MAX;
        return r;
    endfunction

endpackage

>>> rtl/windowed_utilization_threshold_monitor_top.sv
`timescale 1ns / 1ps
// An accepted input beat passes through fraction setup, the fraction divide (skipped
// for zero, inverted or fully busy deltas), the window update, the average setup and divide
// (skipped until the window has filled) and finish, which loads the output register.
// A new input beat is taken only after that load; the shared divider makes one bit per cycle.
// Reset: clears counters, window sum, position, flags and output valid, and loads the register
// defaults; no clearing pass, since the fill flag masks window entries never written.
// ----------------------------------------------------------------------------
// Windowed utilization threshold monitor
// Turns cumulative tick counters into a busy fraction, averages it over a
// circular window and runs two hysteresis thresholds on the average.
// ----------------------------------------------------------------------------
module windowed_utilization_threshold_monitor_top #(
    parameter int MAX_WINDOW      = wutm_pkg::MAX_WINDOW_DEFAULT,
    parameter int THRESHOLD_COUNT = wutm_pkg::THRESHOLD_COUNT_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  wutm_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output wutm_pkg::out_item_t                   out_data,
    input  logic                                  cfg_write,
    input  logic [wutm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wutm_pkg::CFG_W-1:0]            cfg_data
);

    import wutm_pkg::*;

    // Window geometry. The sum of MAX_WINDOW 16-bit fractions fits in SUM_W bits,
    // and the average dividend (sum times 100) in PROD_W bits.
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = FRAC_W + $clog2(MAX_WINDOW);
    localparam int PROD_W = SUM_W + 7;
    localparam int DIV_W  = TICK_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WLEN_W-1:0]        wlen_reg;
    logic [1:0][PCT_W-1:0]    level_reg;
    logic [1:0][PCT_W-1:0]    hyst_reg;
    logic [ACTION_W-1:0]      action_reg;
    logic                     restart;

    assign restart = cfg_write && (cfg_index == REG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg   <= WINDOW_LENGTH_RESET;
            level_reg  <= {LEVEL_RESET, LEVEL_RESET};
            hyst_reg   <= '0;
            action_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH:     wlen_reg     <= cfg_data[WLEN_W-1:0];
                REG_FIRST_LEVEL:       level_reg[0] <= cfg_data[PCT_W-1:0];
                REG_FIRST_HYSTERESIS:  hyst_reg[0]  <= cfg_data[PCT_W-1:0];
                REG_SECOND_LEVEL:      level_reg[1] <= cfg_data[PCT_W-1:0];
                REG_SECOND_HYSTERESIS: hyst_reg[1]  <= cfg_data[PCT_W-1:0];
                REG_ACTION_BITS:       action_reg   <= cfg_data[ACTION_W-1:0];
                default:               ;
            endcase
        end
    end

    // The effective window length is the register clamped to 1..MAX_WINDOW.
    logic [LEN_W-1:0] len_eff;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            len_eff = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = LEN_W'(wlen_reg);
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;
    logic   in_take;
    logic   out_free;
    logic   out_load;
    logic   cnt_done;
    logic   filled_next;

    logic [4:0] cnt_reg;

    // Tick deltas of the item in flight, loaded when its beat is accepted.
    logic [TICK_W-1:0] dt_reg;
    logic [TICK_W-1:0] di_reg;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;
    assign cnt_done = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_FRAC_SETUP;
                end
            end
            ST_FRAC_SETUP:
            begin
                state_next = ST_UPDATE;
                if ((dt_reg != '0) && (di_reg <= dt_reg) && (di_reg != '0))
                begin
                    state_next = ST_FRAC_DIV;
                end
            end
            ST_FRAC_DIV:
            begin
                if (cnt_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = filled_next ? ST_AVG_SETUP : ST_FINISH;
            end
            ST_AVG_SETUP:
            begin
                state_next = ST_AVG_DIV;
            end
            ST_AVG_DIV:
            begin
                if (cnt_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Tick deltas
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] prev_total_reg;
    logic [TICK_W-1:0] prev_idle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_total_reg <= '0;
            prev_idle_reg  <= '0;
        end
        else if (in_take)
        begin
            prev_total_reg <= in_data.total_ticks;
            prev_idle_reg  <= in_data.idle_ticks;
        end
    end

    // Deltas wrap modulo 2^32, which plain unsigned subtraction gives.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dt_reg <= in_data.total_ticks - prev_total_reg;
            di_reg <= in_data.idle_ticks - prev_idle_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shared restoring divider, one quotient bit per cycle
    // ------------------------------------------------------------------
    // The partial remainder stays below the divisor. Each step shifts in the
    // next dividend bit from the dividend shift register and subtracts the
    // divisor when it fits. The fraction divide runs 16 steps with zero bits
    // shifted in; the average divide runs 15 steps over the low dividend bits.
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [FRAC_W-1:0] sh_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [DIV_W:0]    div_trial;
    logic [DIV_W:0]    div_diff;
    logic              div_ge;
    logic [DIV_W-1:0]  rem_step;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod;

    assign div_trial = {rem_reg, sh_reg[FRAC_W-1]};
    assign div_diff  = div_trial - {1'b0, div_reg};
    assign div_ge    = (div_trial >= {1'b0, div_reg});
    assign rem_step  = div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];

    // Window sum times 100 as a shift-and-add: 100 = 64 + 32 + 4.
    assign prod = (PROD_W'(sum_reg) << 6) + (PROD_W'(sum_reg) << 5)
                + (PROD_W'(sum_reg) << 2);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_FRAC_SETUP:
            begin
                // Zero total delta or more idle than total gives an empty
                // fraction; no idle at all saturates, since the quotient
                // would be exactly 65536.
                if ((dt_reg == '0) || (di_reg > dt_reg))
                begin
                    quo_reg <= '0;
                end
                else if (di_reg == '0)
                begin
                    quo_reg <= FRAC_FULL;
                end
                else
                begin
                    rem_reg <= dt_reg - di_reg;
                    div_reg <= dt_reg;
                    sh_reg  <= '0;
                    cnt_reg <= 5'(FRAC_W - 1);
                end
            end
            ST_AVG_SETUP:
            begin
                // The quotient is below 2^15, so the top dividend bits
                // already sit below the divisor L * 256.
                rem_reg <= DIV_W'(prod[PROD_W-1:PCT_W]);
                div_reg <= DIV_W'({len_eff, 8'b0});
                sh_reg  <= {prod[PCT_W-1:0], 1'b0};
                cnt_reg <= 5'(PCT_W - 1);
            end
            ST_FRAC_DIV, ST_AVG_DIV:
            begin
                rem_reg <= rem_step;
                sh_reg  <= {sh_reg[FRAC_W-2:0], 1'b0};
                quo_reg <= {quo_reg[FRAC_W-2:0], div_ge};
                cnt_reg <= cnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Fraction window and running sum
    // ------------------------------------------------------------------
    // Writes after a restart go to positions 0, 1, 2 and so on, so an entry
    // has been written exactly when the window has wrapped once; until then
    // the old entry reads as zero.
    logic [POS_W-1:0]  pos_reg;
    logic              filled_reg;
    logic [FRAC_W-1:0] ram_rdata;
    logic [FRAC_W-1:0] old_frac;
    logic [SUM_W-1:0]  sum_next;
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  pos_inc;
    logic [POS_W-1:0]  pos_next;
    logic              ram_we;

    assign ram_we   = (state_reg == ST_UPDATE);
    assign old_frac = filled_reg ? ram_rdata : '0;
    assign sum_next = sum_reg - SUM_W'(old_frac) + SUM_W'(quo_reg);
    assign pos_ext  = LEN_W'(pos_reg);
    assign pos_inc  = pos_ext + LEN_W'(1);
    assign pos_next = (pos_inc >= len_eff) ? '0 : POS_W'(pos_inc);
    assign filled_next = filled_reg || (pos_ext == (len_eff - LEN_W'(1)));

    wutm_ram #(
        .WIDTH (FRAC_W),
        .DEPTH (MAX_WINDOW)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (quo_reg),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (restart)
        begin
            sum_reg    <= '0;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            sum_reg    <= sum_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
        end
    end

    // ------------------------------------------------------------------
    // Threshold checks with hysteresis
    // ------------------------------------------------------------------
    // Thresholds are visited in order, so a later one can undo the error
    // bit that an earlier one set on the same item.
    logic [PCT_W-1:0] avg;
    logic [1:0]       flags_reg;
    logic             err_reg;
    logic [1:0]       flags_next;
    logic             err_next;
    logic [1:0]       aev;
    logic [1:0]       dev;
    logic [1:0]       lev;
    logic             reboot;

    assign avg = filled_reg ? quo_reg[PCT_W-1:0] : '0;

    always_comb
    begin
        logic [PCT_W-1:0]  lvl;
        logic signed [16:0] low;
        logic [2:0]        act;
        flags_next = flags_reg;
        err_next   = err_reg;
        aev        = '0;
        dev        = '0;
        lev        = '0;
        reboot     = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            lvl = clamp_level(level_reg[i]);
            low = $signed({2'b0, lvl}) - $signed({2'b0, hyst_reg[i]});
            act = action_reg[3*i +: 3];
            if (filled_reg && (i < THRESHOLD_COUNT))
            begin
                if (!flags_next[i] && (avg >= lvl))
                begin
                    flags_next[i] = 1'b1;
                    aev[i]        = 1'b1;
                    lev[i]        = act[ACT_LOG];
                    if (act[ACT_REBOOT])
                    begin
                        reboot = 1'b1;
                    end
                    if (act[ACT_ERROR])
                    begin
                        err_next = 1'b1;
                    end
                end
                if (flags_next[i] && ($signed({2'b0, avg}) < low))
                begin
                    flags_next[i] = 1'b0;
                    dev[i]        = 1'b1;
                    lev[i]        = act[ACT_LOG];
                    if (act[ACT_ERROR])
                    begin
                        err_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (out_load)
        begin
            flags_reg <= flags_next;
            err_reg   <= err_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    // A finished beat waits here while the block returns to idle and takes
    // the next input beat.
    logic      out_valid_reg;
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.average_percent <= avg;
            out_data_reg.average_valid   <= filled_reg;
            out_data_reg.asserted_mask   <= flags_next;
            out_data_reg.assert_events   <= aev;
            out_data_reg.deassert_events <= dev;
            out_data_reg.log_events      <= lev;
            out_data_reg.reboot_request  <= reboot;
            out_data_reg.health_error    <= err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/wutm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wutm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> dv/windowed_utilization_threshold_monitor_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed utilization threshold monitor testbench
// Feeds cumulative tick counter samples through the valid/stall input channel
// and checks every report beat against a local model of the busy fraction,
// the sliding window average and the two hysteresis thresholds.
// ----------------------------------------------------------------------------
module windowed_utilization_threshold_monitor_top_test;

    import wutm_pkg::*;

    localparam int MAX_WIN     = MAX_WINDOW_DEFAULT;
    localparam int THRESHOLDS  = THRESHOLD_COUNT_DEFAULT;
    // Cycles with no beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_HIGH = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    windowed_utilization_threshold_monitor_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies held by the model. They follow every write on the
    // configuration port and start at the documented reset values.
    logic [WLEN_W-1:0]   cfg_wlen = WINDOW_LENGTH_RESET;
    logic [PCT_W-1:0]    cfg_level [2] = '{LEVEL_RESET, LEVEL_RESET};
    logic [PCT_W-1:0]    cfg_margin [2] = '{default: '0};
    logic [ACTION_W-1:0] cfg_act = '0;

    // Model state: the last counter sample, the fraction history with its
    // running sum, and the threshold and health flags.
    logic [TICK_W-1:0]   last_total = '0;
    logic [TICK_W-1:0]   last_idle = '0;
    logic [FRAC_W-1:0]   frac_hist [MAX_WIN] = '{default: '0};
    logic [22:0]         hist_sum = '0;
    int unsigned         wr_pos = 0;
    bit                  hist_full = 1'b0;
    logic [1:0]          flag_mask = '0;
    logic                err_bit = 1'b0;

    // Reports predicted for accepted samples, oldest first.
    out_item_t           pending_reports [$];

    // The counters of the imaginary host that the samples are taken from.
    logic [TICK_W-1:0]   host_total = '0;
    logic [TICK_W-1:0]   host_idle = '0;

    int                  mismatches = 0;
    int                  beats_seen = 0;
    int                  quiet_cycles = 0;
    // When set, neither side inserts idle cycles between beats.
    bit                  steady = 1'b0;
    // A receiver hold-off request in cycles, taken up after the next beat.
    int                  hold_span = 0;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Any beat on either channel or any register write counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model of the block: one report per sample
    // ------------------------------------------------------------------------
    // The fraction is computed from the counter deltas with 32-bit wrap. An
    // empty interval or an idle delta larger than the total delta gives zero,
    // and a fully busy interval saturates at the top of Q0.16. The average is
    // the window sum scaled to percent Q8, and the thresholds are evaluated
    // in order, each asserting at or above its clamped level and releasing
    // strictly below level minus margin.
    function automatic out_item_t predict_report(input in_item_t beat);
        out_item_t         r;
        logic [TICK_W-1:0] dt;
        logic [TICK_W-1:0] di;
        logic [63:0]       quot;
        logic [63:0]       avg_wide;
        logic [FRAC_W-1:0] frac;
        logic [PCT_W-1:0]  lvl;
        logic [2:0]        act;
        int unsigned       len;
        int unsigned       pos;
        int                low;
        int                i;
        r = '0;
        dt = beat.total_ticks - last_total;
        di = beat.idle_ticks - last_idle;
        if (dt == '0 || di > dt)
            frac = '0;
        else
        begin
            quot = ({32'd0, dt - di} << 16) / {32'd0, dt};
            frac = (quot > 64'd65535) ? FRAC_FULL : quot[FRAC_W-1:0];
        end
        last_total = beat.total_ticks;
        last_idle = beat.idle_ticks;

        len = (cfg_wlen == '0) ? 1 : ((cfg_wlen > MAX_WIN) ? MAX_WIN : cfg_wlen);
        pos = (wr_pos >= len) ? 0 : wr_pos;
        hist_sum = hist_sum - frac_hist[pos] + frac;
        frac_hist[pos] = frac;
        if (pos == len - 1)
            hist_full = 1'b1;
        wr_pos = (pos + 1 >= len) ? 0 : pos + 1;

        if (hist_full)
        begin
            avg_wide = (64'(hist_sum) * 64'd100) / (64'(len) * 64'd256);
            r.average_valid = 1'b1;
            r.average_percent = avg_wide[PCT_W-1:0];
            for (i = 0; i < THRESHOLDS && i < 2; i++)
            begin
                lvl = cfg_level[i];
                if (lvl < LEVEL_MIN)
                    lvl = LEVEL_MIN;
                if (lvl > LEVEL_MAX)
                    lvl = LEVEL_MAX;
                low = int'(lvl) - int'(cfg_margin[i]);
                act = cfg_act[3*i +: 3];
                if (!flag_mask[i] && avg_wide >= 64'(lvl))
                begin
                    flag_mask[i] = 1'b1;
                    r.assert_events[i] = 1'b1;
                    if (act[ACT_LOG])
                        r.log_events[i] = 1'b1;
                    if (act[ACT_REBOOT])
                        r.reboot_request = 1'b1;
                    if (act[ACT_ERROR])
                        err_bit = 1'b1;
                end
                if (flag_mask[i] && int'(avg_wide) < low)
                begin
                    flag_mask[i] = 1'b0;
                    r.deassert_events[i] = 1'b1;
                    if (act[ACT_LOG])
                        r.log_events[i] = 1'b1;
                    if (act[ACT_ERROR])
                        err_bit = 1'b0;
                end
            end
        end
        r.asserted_mask = flag_mask;
        r.health_error = err_bit;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Offers one sample beat after a random number of idle cycles and returns
    // at the edge where it is accepted, with valid still high so that a
    // following beat can go out without a gap.
    task automatic send_sample(input logic [TICK_W-1:0] total, input logic [TICK_W-1:0] idle);
        in_item_t beat;
        int       gap;
        beat.total_ticks = total;
        beat.idle_ticks = idle;
        host_total = total;
        host_idle = idle;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_reports.push_back(predict_report(beat));
    endtask

    // A register write ends with the strobe low, so that the write strobe is never
    // lowered and raised again within one time step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        int k;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WINDOW_LENGTH:
            begin
                // A new window length throws away the history but keeps the
                // last counter sample and the flags.
                cfg_wlen = value[WLEN_W-1:0];
                for (k = 0; k < MAX_WIN; k++)
                    frac_hist[k] = '0;
                hist_sum = '0;
                wr_pos = 0;
                hist_full = 1'b0;
            end
            REG_FIRST_LEVEL:       cfg_level[0] = value;
            REG_FIRST_HYSTERESIS:  cfg_margin[0] = value;
            REG_SECOND_LEVEL:      cfg_level[1] = value;
            REG_SECOND_HYSTERESIS: cfg_margin[1] = value;
            REG_ACTION_BITS:       cfg_act = value[ACTION_W-1:0];
            default: ;
        endcase
    endtask

    // Drops valid and waits until every predicted report has come back, so
    // that the block is idle and registers may be written.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Host load model. Most beats are regular samples whose busy share
    // follows a load level that holds for a while and then jumps, so that the
    // window average rises through and falls back across the thresholds. The
    // rest are arbitrary counter values, empty intervals, idle running ahead
    // of total, and fully busy intervals.
    task automatic send_load_beats(input int count, input int span);
        int unsigned load_pm;
        int unsigned load_left;
        int unsigned busy_pm;
        logic [TICK_W-1:0] dt;
        logic [63:0] busy_ticks;
        int n;
        load_pm = 500;
        load_left = 0;
        for (n = 0; n < count; n++)
        begin
            if (load_left == 0)
            begin
                case ($urandom_range(0, 7))
                    0: load_pm = 300;
                    1: load_pm = 550;
                    2: load_pm = 620;
                    3: load_pm = 700;
                    4: load_pm = 780;
                    5: load_pm = 850;
                    6: load_pm = 920;
                    default: load_pm = 1000;
                endcase
                load_left = $urandom_range(1, 3 * span + 4);
            end
            load_left--;
            case ($urandom_range(0, 19))
                0: send_sample($urandom, $urandom);
                1: send_sample(host_total, host_idle + $urandom_range(0, 50));
                2:
                begin
                    dt = $urandom_range(1, 500);
                    send_sample(host_total + dt, host_idle + dt + $urandom_range(1, 500));
                end
                3: send_sample(host_total + $urandom_range(1, 1000000), host_idle);
                default:
                begin
                    dt = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 100000);
                    busy_pm = load_pm + $urandom_range(0, 60);
                    busy_pm = (busy_pm < 30) ? 0 : busy_pm - 30;
                    if (busy_pm > 1000)
                        busy_pm = 1000;
                    busy_ticks = (64'(dt) * 64'(busy_pm)) / 64'd1000;
                    send_sample(host_total + dt, host_idle + (dt - busy_ticks[TICK_W-1:0]));
                end
            endcase
        end
    endtask

    // Levels are mostly inside the clamp range, sometimes at or past its ends.
    function automatic logic [CFG_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 15'h7FFF;
            2: return LEVEL_MIN;
            3: return LEVEL_MAX;
            default: return CFG_W'($urandom_range(LEVEL_MIN, LEVEL_MAX));
        endcase
    endfunction

    // Margins are mostly small; a margin above the level pins the threshold.
    function automatic logic [CFG_W-1:0] pick_margin();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 15'h7FFF;
            2: return 15'd25600;
            default: return CFG_W'($urandom_range(0, 3000));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------
    // The receiver stalls a random number of cycles before each report beat.
    // A pending hold-off request replaces one such pause with a long one.
    initial
    begin : report_sink
        int gap;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_span != 0)
                gap = hold_span;
            else
                gap = steady ? 0 : $urandom_range(0, 14);
            hold_span = 0;
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("report beat %0d: %s expected %0d, got %0d", beats_seen, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : report_check
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report beat %0d arrived with no sample outstanding", beats_seen);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("average_percent", want.average_percent, out_data.average_percent);
                check_field("average_valid", want.average_valid, out_data.average_valid);
                check_field("asserted_mask", want.asserted_mask, out_data.asserted_mask);
                check_field("assert_events", want.assert_events, out_data.assert_events);
                check_field("deassert_events", want.deassert_events, out_data.deassert_events);
                check_field("log_events", want.log_events, out_data.log_events);
                check_field("reboot_request", want.reboot_request, out_data.reboot_request);
                check_field("health_error", want.health_error, out_data.health_error);
            end
            beats_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Right after reset the window is 120 samples long, so the first beats
    // report no average while the flags read back as clear.
    task automatic test_reset_state();
        send_sample(32'd0, 32'd0);
        send_sample(32'd1000, 32'd0);
        send_sample(32'd1600, 32'd300);
    endtask

    // Keeps the reset registers and runs long enough for the default window
    // to fill and the 90 percent thresholds to see real averages.
    task automatic test_default_window();
        send_load_beats(130, 120);
        wait_until_drained();
    endtask

    // A one-sample window makes the average follow each fraction directly,
    // which exposes the fraction corner cases and counter wrap. All actions
    // are on, so the log, reboot and error outputs move as well.
    task automatic test_fraction_corners();
        write_register(REG_WINDOW_LENGTH, 15'd1);
        write_register(REG_ACTION_BITS, 15'h3F);
        send_sample(host_total + 32'd1000, host_idle);          // fully busy
        send_sample(host_total, host_idle + 32'd5);             // no time passed
        send_sample(host_total + 32'd10, host_idle + 32'd20);   // idle ran ahead
        send_sample(host_total + 32'd500, host_idle + 32'd500); // fully idle
        send_sample(32'hFFFF_FFFF, 32'h0000_0000);
        send_sample(32'h0000_0000, 32'hFFFF_FFFF);
        send_sample(32'h0000_0060, 32'h0000_0008);              // idle counter wraps
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        wait_until_drained();
    endtask

    // Both thresholds drive the one health bit. The upper threshold
    // releasing clears it even though the lower one is still asserted.
    task automatic test_shared_error_bit();
        write_register(REG_FIRST_LEVEL, LEVEL_MIN);
        write_register(REG_FIRST_HYSTERESIS, 15'd0);
        write_register(REG_SECOND_LEVEL, LEVEL_MAX);
        write_register(REG_SECOND_HYSTERESIS, 15'd0);
        write_register(REG_ACTION_BITS, CFG_W'((1 << ACT_ERROR) | (1 << (3 + ACT_ERROR))));
        send_sample(host_total + 32'd1000, host_idle + 32'd50);   // 95 percent
        send_sample(host_total + 32'd1000, host_idle + 32'd250);  // 75 percent
        send_sample(host_total + 32'd1000, host_idle + 32'd50);
        send_sample(host_total + 32'd1000, host_idle + 32'd700);  // 30 percent
        wait_until_drained();
    endtask

    // Writing a level halfway through filling must not restart the window,
    // and writes to unmapped indexes must leave every register alone.
    task automatic test_register_isolation();
        write_register(REG_WINDOW_LENGTH, 15'd4);
        send_sample(host_total + 32'd800, host_idle + 32'd100);
        send_sample(host_total + 32'd800, host_idle + 32'd50);
        wait_until_drained();
        write_register(REG_FIRST_LEVEL, 15'd19000);
        write_register(UNMAPPED_REG_LOW, 15'h7FFF);
        write_register(UNMAPPED_REG_HIGH, 15'h7FFF);
        send_sample(host_total + 32'd800, host_idle + 32'd20);
        send_sample(host_total + 32'd800, host_idle + 32'd10);
        send_sample(host_total + 32'd800, host_idle + 32'd600);
        wait_until_drained();
    endtask

    // The receiver takes up a hold-off request while samples keep coming with no
    // gaps, so the block fills up and has to stall its input.
    task automatic test_back_pressure();
        write_register(REG_WINDOW_LENGTH, 15'd3);
        write_register(REG_ACTION_BITS, CFG_W'($urandom_range(0, 63)));
        steady = 1'b1;
        hold_span = 400;
        send_load_beats(40, 3);
        wait_until_drained();
        steady = 1'b0;
    endtask

    // One phase per window setting, from the clamped-up zero through the
    // maximum and past it, with upper data bits set on some writes. Every
    // phase draws fresh levels, margins and actions.
    task automatic test_random_windows();
        logic [CFG_W-1:0] lengths [10];
        int               span;
        int               p;
        lengths = '{15'd0, 15'd1, 15'd2, 15'd3, 15'd5, 15'd8, 15'd16, 15'h7F80, 15'h00FF,
                    {7'($urandom), 8'($urandom_range(1, 40))}};
        for (p = 0; p < 10; p++)
        begin
            write_register(REG_WINDOW_LENGTH, lengths[p]);
            write_register(REG_FIRST_LEVEL, pick_level());
            write_register(REG_FIRST_HYSTERESIS, pick_margin());
            write_register(REG_SECOND_LEVEL, pick_level());
            write_register(REG_SECOND_HYSTERESIS, pick_margin());
            case ($urandom_range(0, 5))
                0: write_register(REG_ACTION_BITS, 15'h00);
                1: write_register(REG_ACTION_BITS, 15'h3F);
                default: write_register(REG_ACTION_BITS, CFG_W'($urandom_range(0, 63)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            span = lengths[p][WLEN_W-1:0];
            if (span < 1)
                span = 1;
            if (span > MAX_WIN)
                span = MAX_WIN;
            send_load_beats(span + ((span > 64) ? 60 : 80), span);
            wait_until_drained();
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_default_window();
        test_fraction_corners();
        test_shared_error_bit();
        test_register_isolation();
        test_back_pressure();
        test_random_windows();

        // Everything has come back; leave room for a late stray beat, which
        // can be at most one full item latency away.
        wait_until_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/wutm_pkg.sv
rtl/wutm_ram.sv
rtl/windowed_utilization_threshold_monitor_top.sv
dv/windowed_utilization_threshold_monitor_top_test.sv
